/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master transaction sequencer: command
// and phase codes, status codes, bus status keys and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

   // default store depths
   localparam int TX_DEPTH_DEF = 8;
   localparam int RX_DEPTH_DEF = 8;

   // command codes of an input word
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2,
      OP_EVENT = 2'd3
   } opcode_type;

   // transaction phase
   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_STARTING  = 2'd1,
      PH_SENDING   = 2'd2,
      PH_RECEIVING = 2'd3
   } phase_type;

   // transfer direction, same codes as the start command's kind field
   localparam logic [1:0] DIR_WRITE      = 2'd0;
   localparam logic [1:0] DIR_READ       = 2'd1;
   localparam logic [1:0] DIR_WRITE_READ = 2'd2;
   localparam logic [1:0] KIND_RESERVED  = 2'd3;

   // result status
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BUSY     = 3'd1,
      ST_TX_FULL  = 3'd2,
      ST_RX_EMPTY = 3'd3,
      ST_PROTO    = 3'd4,
      ST_RX_OVER  = 3'd5
   } status_type;

   // bus status keys {master, transmitter, start, stop}
   localparam logic [3:0] KEY_ADDR_SENT = 4'hE;
   localparam logic [3:0] KEY_TX_BYTE   = 4'hC;
   localparam logic [3:0] KEY_RX_BYTE   = 4'h8;

   // one result word
   typedef struct packed {
      status_type  status;
      logic        drive_valid;
      logic [7:0]  drive_byte;
      logic        clear_start_stop;
      logic        request_start;
      logic        request_stop;
      logic        ack_valid;
      logic        ack_value;
      logic [7:0]  read_byte;
      logic [1:0]  phase_now;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/i2cms_decode.sv */
// ----------------------------------------------------------------------------
// i2cms_decode
// Per-word decision logic: from the current sequencer state and one input
// word, the next state, the store write and read strobes and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_decode
   import i2cms_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   localparam int TXW = $clog2(TX_DEPTH + 1),
   localparam int RXW = $clog2(RX_DEPTH + 1)
) (
   // input word
   input  wire logic [1:0]     opcode,
   input  wire logic [6:0]     target_address,
   input  wire logic [1:0]     transfer_kind,
   input  wire logic [7:0]     read_count,
   input  wire logic           ev_master,
   input  wire logic           ev_transmitter,
   input  wire logic           ev_start_flag,
   input  wire logic           ev_stop_flag,
   input  wire logic           ev_ack,
   // current state
   input  wire phase_type      phase,
   input  wire logic [6:0]     slave_address,
   input  wire logic [1:0]     direction,
   input  wire logic [TXW-1:0] tx_rd,
   input  wire logic [TXW-1:0] tx_wr,
   input  wire logic [RXW-1:0] rx_rd,
   input  wire logic [RXW-1:0] rx_wr,
   input  wire logic [7:0]     rx_limit,
   // next state
   output phase_type           phase_in,
   output logic [6:0]          slave_address_in,
   output logic [1:0]          direction_in,
   output logic [TXW-1:0]      tx_rd_in,
   output logic [TXW-1:0]      tx_wr_in,
   output logic [RXW-1:0]      rx_rd_in,
   output logic [RXW-1:0]      rx_wr_in,
   output logic [7:0]          rx_limit_in,
   // store strobes, addresses are the current indices
   output logic                tx_we,
   output logic                tx_re,
   output logic                rx_we,
   output logic                rx_re,
   // result word, store bytes are merged in later
   output rsp_type             rsp
);

   logic [3:0]     key;
   logic           to_write;
   logic [RXW-1:0] rx_wr_eff;

   assign key = {ev_master, ev_transmitter, ev_start_flag, ev_stop_flag};

   // next state and result
   always_comb begin
      phase_in         = phase;
      slave_address_in = slave_address;
      direction_in     = direction;
      tx_rd_in         = tx_rd;
      tx_wr_in         = tx_wr;
      rx_rd_in         = rx_rd;
      rx_wr_in         = rx_wr;
      rx_limit_in      = rx_limit;
      tx_we            = 1'b0;
      tx_re            = 1'b0;
      rx_we            = 1'b0;
      rx_re            = 1'b0;
      rsp              = '0;
      to_write         = (direction == DIR_WRITE) || (direction == DIR_WRITE_READ);
      rx_wr_eff        = rx_wr;

      unique case (opcode_type'(opcode))
         OP_START: begin
            if (phase != PH_IDLE) begin
               rsp.status = ST_BUSY;
            end else begin
               slave_address_in  = target_address;
               direction_in      = (transfer_kind == KIND_RESERVED) ? DIR_READ
                                                                    : transfer_kind;
               rx_limit_in       = read_count;
               tx_rd_in          = '0;
               tx_wr_in          = '0;
               rx_rd_in          = '0;
               rx_wr_in          = '0;
               phase_in          = PH_STARTING;
               rsp.request_start = 1'b1;
            end
         end
         OP_PUSH: begin
            if (tx_wr >= TXW'(TX_DEPTH)) begin
               rsp.status = ST_TX_FULL;
            end else begin
               tx_we    = 1'b1;
               tx_wr_in = tx_wr + 1'b1;
            end
         end
         OP_POP: begin
            if ((rx_rd >= rx_wr) || (rx_rd >= RXW'(RX_DEPTH))) begin
               rsp.status = ST_RX_EMPTY;
            end else begin
               rx_re = 1'b1;
               // last stored byte taken: shrink the limit and rewind
               if (rx_rd + 1'b1 == rx_wr) begin
                  rx_limit_in = rx_limit - 8'(rx_wr);
                  rx_rd_in    = '0;
                  rx_wr_in    = '0;
               end else begin
                  rx_rd_in = rx_rd + 1'b1;
               end
            end
         end
         OP_EVENT: begin
            if ((key == KEY_ADDR_SENT) && (phase == PH_STARTING)) begin
               // address byte with read/write bit
               rsp.clear_start_stop = 1'b1;
               rsp.drive_valid      = 1'b1;
               rsp.drive_byte       = {slave_address, ~to_write};
               phase_in             = to_write ? PH_SENDING : PH_RECEIVING;
            end else if ((key == KEY_TX_BYTE) && (phase == PH_SENDING)) begin
               if (ev_ack && (tx_rd < tx_wr) && (tx_rd < TXW'(TX_DEPTH))) begin
                  rsp.drive_valid = 1'b1;
                  tx_re           = 1'b1;
                  if (tx_rd + 1'b1 == tx_wr) begin
                     tx_rd_in = '0;
                     tx_wr_in = '0;
                  end else begin
                     tx_rd_in = tx_rd + 1'b1;
                  end
               end else if (direction == DIR_WRITE_READ) begin
                  // repeated start for the read part
                  rsp.request_start = 1'b1;
                  direction_in      = DIR_READ;
                  phase_in          = PH_STARTING;
               end else begin
                  rsp.request_stop = 1'b1;
                  phase_in         = PH_IDLE;
               end
            end else if ((key == KEY_TX_BYTE) && (phase == PH_RECEIVING)) begin
               if (ev_ack) begin
                  rsp.ack_valid = 1'b1;
                  rsp.ack_value = (9'(rx_wr) + 9'd1) != {1'b0, rx_limit};
               end else begin
                  rsp.request_stop = 1'b1;
                  phase_in         = PH_IDLE;
               end
            end else if ((key == KEY_RX_BYTE) && (phase == PH_RECEIVING)) begin
               if (8'(rx_wr) < rx_limit) begin
                  if (rx_wr < RXW'(RX_DEPTH)) begin
                     rx_we     = 1'b1;
                     rx_wr_eff = rx_wr + 1'b1;
                  end else begin
                     rsp.status = ST_RX_OVER;
                  end
               end
               rx_wr_in = rx_wr_eff;
               if (8'(rx_wr_eff) < rx_limit) begin
                  rsp.ack_valid = 1'b1;
                  rsp.ack_value = (9'(rx_wr_eff) + 9'd1) != {1'b0, rx_limit};
               end else begin
                  rsp.request_stop = 1'b1;
                  phase_in         = PH_IDLE;
               end
            end else begin
               // unexpected bus status: back to idle, stores emptied
               rsp                  = '0;
               rsp.status           = ST_PROTO;
               rsp.clear_start_stop = 1'b1;
               tx_rd_in             = '0;
               tx_wr_in             = '0;
               rx_rd_in             = '0;
               rx_wr_in             = '0;
               phase_in             = PH_IDLE;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase

      rsp.phase_now = phase_in;
   end

endmodule

`default_nettype wire

/* rtl/i2c_master_transaction_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Sequences I2C master write, read and write-then-read transactions from host
// commands and bus core events; transmit and receive bytes sit in two small
// synchronous memories.
//
//   channel   ports   direction   contents
//   request   req_*   in          command or bus event word
//   response  rsp_*   out         drive, start/stop/ack controls, data, status
//
// One word per cycle is accepted while req_ready is high; each word yields
// one registered response word. The decision is made in the accept cycle
// from the index registers; the memory read for a transmit or popped byte
// lands in the output register on the same edge. A second output register
// takes a word while the first one is stalled, so req_ready only drops when
// both are full. Synchronous reset clears the phase, address, direction,
// indices and limit; memory contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer
   import i2cms_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_opcode,
   input  wire logic [6:0] req_target_address,
   input  wire logic [1:0] req_transfer_kind,
   input  wire logic [7:0] req_read_count,
   input  wire logic [7:0] req_push_byte,
   input  wire logic       req_ev_master,
   input  wire logic       req_ev_transmitter,
   input  wire logic       req_ev_start_flag,
   input  wire logic       req_ev_stop_flag,
   input  wire logic       req_ev_ack,
   input  wire logic [7:0] req_bus_rx_byte,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic            rsp_drive_valid,
   output logic [7:0]      rsp_drive_byte,
   output logic            rsp_clear_start_stop,
   output logic            rsp_request_start,
   output logic            rsp_request_stop,
   output logic            rsp_ack_valid,
   output logic            rsp_ack_value,
   output logic [7:0]      rsp_read_byte,
   output logic [1:0]      rsp_phase_now
);

   localparam int TXW = $clog2(TX_DEPTH + 1);
   localparam int RXW = $clog2(RX_DEPTH + 1);
   localparam int TXA = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RXA = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

   // sequencer state
   phase_type      phase_ff, phase_in;
   logic [6:0]     slave_address_ff, slave_address_in;
   logic [1:0]     direction_ff, direction_in;
   logic [TXW-1:0] tx_rd_ff, tx_rd_in;
   logic [TXW-1:0] tx_wr_ff, tx_wr_in;
   logic [RXW-1:0] rx_rd_ff, rx_rd_in;
   logic [RXW-1:0] rx_wr_ff, rx_wr_in;
   logic [7:0]     rx_limit_ff, rx_limit_in;

   // byte stores
   logic [7:0]     tx_mem_ff [TX_DEPTH];
   logic [7:0]     rx_mem_ff [RX_DEPTH];

   // decision outputs
   logic           tx_we, tx_re, rx_we, rx_re;
   rsp_type        new_rsp;

   // output registers
   rsp_type        main_ff, skid_ff;
   logic           main_valid_ff, skid_valid_ff;
   logic           main_valid_in, skid_valid_in;
   logic           accept, main_free;
   logic           main_load_new, main_load_skid, skid_load;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;

   i2cms_decode #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_decode (
      .opcode           (req_opcode),
      .target_address   (req_target_address),
      .transfer_kind    (req_transfer_kind),
      .read_count       (req_read_count),
      .ev_master        (req_ev_master),
      .ev_transmitter   (req_ev_transmitter),
      .ev_start_flag    (req_ev_start_flag),
      .ev_stop_flag     (req_ev_stop_flag),
      .ev_ack           (req_ev_ack),
      .phase            (phase_ff),
      .slave_address    (slave_address_ff),
      .direction        (direction_ff),
      .tx_rd            (tx_rd_ff),
      .tx_wr            (tx_wr_ff),
      .rx_rd            (rx_rd_ff),
      .rx_wr            (rx_wr_ff),
      .rx_limit         (rx_limit_ff),
      .phase_in         (phase_in),
      .slave_address_in (slave_address_in),
      .direction_in     (direction_in),
      .tx_rd_in         (tx_rd_in),
      .tx_wr_in         (tx_wr_in),
      .rx_rd_in         (rx_rd_in),
      .rx_wr_in         (rx_wr_in),
      .rx_limit_in      (rx_limit_in),
      .tx_we            (tx_we),
      .tx_re            (tx_re),
      .rx_we            (rx_we),
      .rx_re            (rx_re),
      .rsp              (new_rsp)
   );

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         slave_address_ff <= '0;
         direction_ff     <= DIR_WRITE;
         tx_rd_ff         <= '0;
         tx_wr_ff         <= '0;
         rx_rd_ff         <= '0;
         rx_wr_ff         <= '0;
         rx_limit_ff      <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         slave_address_ff <= slave_address_in;
         direction_ff     <= direction_in;
         tx_rd_ff         <= tx_rd_in;
         tx_wr_ff         <= tx_wr_in;
         rx_rd_ff         <= rx_rd_in;
         rx_wr_ff         <= rx_wr_in;
         rx_limit_ff      <= rx_limit_in;
      end
   end

   // store writes; a write and a read never target the same store in one
   // word, and a read in a later word already sees the written byte
   always_ff @(posedge clock) begin
      if (accept && tx_we) begin
         tx_mem_ff[tx_wr_ff[TXA-1:0]] <= req_push_byte;
      end
      if (accept && rx_we) begin
         rx_mem_ff[rx_wr_ff[RXA-1:0]] <= req_bus_rx_byte;
      end
   end

   // output register control
   always_comb begin
      main_free      = ~main_valid_ff | rsp_ready;
      main_load_skid = main_free & skid_valid_ff;
      main_load_new  = main_free & ~skid_valid_ff & accept;
      skid_load      = ~main_free & accept;
      main_valid_in  = main_free ? (skid_valid_ff | accept) : 1'b1;
      skid_valid_in  = main_free ? 1'b0 : (skid_valid_ff | accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // output payload with registered memory read data merged in
   always_ff @(posedge clock) begin : out_payload
      rsp_type load_rsp;
      load_rsp = new_rsp;
      if (tx_re) begin
         load_rsp.drive_byte = tx_mem_ff[tx_rd_ff[TXA-1:0]];
      end
      if (rx_re) begin
         load_rsp.read_byte = rx_mem_ff[rx_rd_ff[RXA-1:0]];
      end
      if (main_load_new) begin
         main_ff <= load_rsp;
      end else if (main_load_skid) begin
         main_ff <= skid_ff;
      end
      if (skid_load) begin
         skid_ff <= load_rsp;
      end
   end

   assign rsp_valid            = main_valid_ff;
   assign rsp_status           = main_ff.status;
   assign rsp_drive_valid      = main_ff.drive_valid;
   assign rsp_drive_byte       = main_ff.drive_byte;
   assign rsp_clear_start_stop = main_ff.clear_start_stop;
   assign rsp_request_start    = main_ff.request_start;
   assign rsp_request_stop     = main_ff.request_stop;
   assign rsp_ack_valid        = main_ff.ack_valid;
   assign rsp_ack_value        = main_ff.ack_value;
   assign rsp_read_byte        = main_ff.read_byte;
   assign rsp_phase_now        = main_ff.phase_now;

   // second output register only fills behind a full first one
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word without a main word");

   // transmit indices stay ordered and within the store
   a_tx_index: assert property (@(posedge clock) disable iff (reset)
      (tx_rd_ff <= tx_wr_ff) && (tx_wr_ff <= TXW'(TX_DEPTH)))
      else $error("transmit index out of order or range");

   // receive indices stay ordered and within the store
   a_rx_index: assert property (@(posedge clock) disable iff (reset)
      (rx_rd_ff <= rx_wr_ff) && (rx_wr_ff <= RXW'(RX_DEPTH)))
      else $error("receive index out of order or range");

   // reset leaves the sequencer idle with no pending response
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_IDLE) && !main_valid_ff && !skid_valid_ff)
      else $error("not idle after reset");

   // a word accepted into an empty output stage shows up on the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && !main_valid_ff) |=> main_valid_ff)
      else $error("accepted word did not reach the output");

endmodule

`default_nettype wire
